// ----- hdl/gbt_pkg.sv -----
package gbt_pkg;

    localparam int VERT_W = 5;
    localparam int COMP_W = 6;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_BFS = 2'd1,
        ACT_DFS = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_COUNT  = 2'd1,
        KIND_ACK    = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [VERT_W-1:0]   vertex;
        logic [COMP_W-1:0]   comps;
        logic                full;
    } t_result;

    typedef enum logic [4:0] {
        S_IDLE,
        S_AD_RD,
        S_AD_WR,
        S_FIN,
        S_BQ,
        S_BU,
        S_BH,
        S_BED,
        S_DROOT,
        S_DRH,
        S_DTOP,
        S_DTP,
        S_DED,
        S_DWH,
        S_DSCAN
    } t_state;

endpackage

// ----- hdl/gbt_ram.sv -----
module gbt_ram
    import gbt_pkg::*;
#(
    parameter int W = 8,
    parameter int D = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    // Simple dual-port RAM; read data is registered and holds between reads.
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/graph_bfs_dfs_traversal_core.sv -----
// Channel   Direction  Handshake                   Word
// input     in         i_in_valid / o_in_stall     action, from_vertex, to_vertex, both_ways
// output    out        o_out_valid / i_out_stall   kind, vertex, components, store_full, last
//
// One item is worked on at a time; o_in_stall is low only while the sequencer is idle.
// An edge add reads the list ends and fills the new slot, then links the slot in, once per
// appended edge, and then finishes. A breadth-first run dequeues each reached vertex, reads
// the list ends of each one that has a list and scans its edges; a depth-first run descends
// into unseen neighbours, skips seen edges and steps through the vertex slots in an
// ascending restart scan. Reset is synchronous and needs no clearing pass: list validity,
// presence and seen marks are flip-flops. A stalled output holds the sequencer only when
// it must hand over a new word.
module graph_bfs_dfs_traversal_core
    import gbt_pkg::*;
#(
    parameter int NODES = 32,
    parameter int EDGES = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_action,
    input  logic [VERT_W-1:0] i_from_vertex,
    input  logic [VERT_W-1:0] i_to_vertex,
    input  logic              i_both_ways,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_kind,
    output logic [VERT_W-1:0] o_vertex,
    output logic [COMP_W-1:0] o_components,
    output logic              o_store_full,
    output logic              o_last
);

    // Vertex index, edge slot index, edge pointer (with null) and count widths.
    localparam int VIW = $clog2(NODES);
    localparam int EAW = $clog2(EDGES);
    localparam int EW  = $clog2(EDGES + 1);
    localparam int CW  = $clog2(NODES + 1);
    localparam logic [EW-1:0] NIL = EW'(EDGES);

    t_state             r_state, n_state;
    logic [VERT_W-1:0]  r_u, n_u;
    logic [VERT_W-1:0]  r_v, n_v;
    logic [VERT_W-1:0]  r_w, n_w;
    logic               r_both, n_both;
    logic               r_second, n_second;
    logic [EW-1:0]      r_used, n_used;
    logic [NODES-1:0]   r_lv, n_lv;
    logic [NODES-1:0]   r_present, n_present;
    logic [NODES-1:0]   r_seen, n_seen;
    logic [CW-1:0]      r_qh, n_qh;
    logic [CW-1:0]      r_qt, n_qt;
    logic [CW-1:0]      r_sp, n_sp;
    logic [CW-1:0]      r_scan, n_scan;
    logic [CW-1:0]      r_comps, n_comps;
    logic               r_pv, n_pv;
    t_result            r_pend, n_pend;
    logic               r_ov, n_ov;
    t_result            r_out, n_out;
    logic               r_olast, n_olast;

    // Memory ports.
    logic                 v_we, v_re;
    logic [VIW-1:0]       v_wa, v_ra;
    logic [2*EW-1:0]      v_wd, v_rd;
    logic                 d_we, d_re;
    logic [EAW-1:0]       d_wa, d_ra;
    logic [VERT_W-1:0]    d_wd, d_rd;
    logic                 x_we, x_re;
    logic [EAW-1:0]       x_wa, x_ra;
    logic [EW-1:0]        x_wd, x_rd;
    logic                 k_we, k_re;
    logic [VIW-1:0]       k_wa, k_ra;
    logic [EW+VERT_W-1:0] k_wd, k_rd;

    logic [EW-1:0] v_head, v_tail, k_ptr;
    logic [VERT_W-1:0] k_vtx;
    assign v_head = v_rd[2*EW-1:EW];
    assign v_tail = v_rd[EW-1:0];
    assign k_ptr  = k_rd[EW+VERT_W-1:VERT_W];
    assign k_vtx  = k_rd[VERT_W-1:0];

    // Adjacency list ends per vertex; valid only where r_lv is set.
    gbt_ram #(.W(2*EW), .D(NODES)) u_vert (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_wa), .i_wdata(v_wd),
        .i_re(v_re), .i_raddr(v_ra), .o_rdata(v_rd)
    );
    // Destination vertex of each edge slot.
    gbt_ram #(.W(VERT_W), .D(EDGES)) u_dest (
        .i_clk(i_clk), .i_we(d_we), .i_waddr(d_wa), .i_wdata(d_wd),
        .i_re(d_re), .i_raddr(d_ra), .o_rdata(d_rd)
    );
    // Link to the next slot of the same list.
    gbt_ram #(.W(EW), .D(EDGES)) u_next (
        .i_clk(i_clk), .i_we(x_we), .i_waddr(x_wa), .i_wdata(x_wd),
        .i_re(x_re), .i_raddr(x_ra), .o_rdata(x_rd)
    );
    // Breadth-first queue or depth-first stack: {edge pointer, vertex}.
    gbt_ram #(.W(EW+VERT_W), .D(NODES)) u_work (
        .i_clk(i_clk), .i_we(k_we), .i_waddr(k_wa), .i_wdata(k_wd),
        .i_re(k_re), .i_raddr(k_ra), .o_rdata(k_rd)
    );

    function automatic t_result mk_vertex(input logic [VERT_W-1:0] v);
        t_result r;
        r.kind   = KIND_VERTEX;
        r.vertex = v;
        r.comps  = '0;
        r.full   = 1'b0;
        return r;
    endfunction

    function automatic t_result mk_other(input t_kind k, input logic [COMP_W-1:0] c,
                                         input logic f);
        t_result r;
        r.kind   = k;
        r.vertex = '0;
        r.comps  = c;
        r.full   = f;
        return r;
    endfunction

    logic         can_emit, push_ok, push, fin;
    t_result      push_res;
    logic [EW:0]  need_sum;
    logic         w_ok;

    assign can_emit = !r_ov || !i_out_stall;
    // One result is held back so that the final one of an item can carry last.
    assign push_ok  = !r_pv || can_emit;
    assign need_sum = {1'b0, r_used} + (i_both_ways ? (EW+1)'(2) : (EW+1)'(1));
    assign w_ok     = (int'(d_rd) < NODES) && !r_seen[VIW'(d_rd)];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_lv      <= '0;
            r_present <= '0;
            r_seen    <= '0;
            r_pv      <= 1'b0;
            r_ov      <= 1'b0;
            r_second  <= 1'b0;
            r_qh      <= '0;
            r_qt      <= '0;
            r_sp      <= '0;
            r_scan    <= '0;
            r_comps   <= '0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_lv      <= n_lv;
            r_present <= n_present;
            r_seen    <= n_seen;
            r_pv      <= n_pv;
            r_ov      <= n_ov;
            r_second  <= n_second;
            r_qh      <= n_qh;
            r_qt      <= n_qt;
            r_sp      <= n_sp;
            r_scan    <= n_scan;
            r_comps   <= n_comps;
        end
        r_u     <= n_u;
        r_v     <= n_v;
        r_w     <= n_w;
        r_both  <= n_both;
        r_pend  <= n_pend;
        r_out   <= n_out;
        r_olast <= n_olast;
    end

    always_comb begin
        n_state = r_state;
        n_u = r_u; n_v = r_v; n_w = r_w; n_both = r_both; n_second = r_second;
        n_used = r_used; n_lv = r_lv; n_present = r_present; n_seen = r_seen;
        n_qh = r_qh; n_qt = r_qt; n_sp = r_sp; n_scan = r_scan; n_comps = r_comps;
        push = 1'b0; fin = 1'b0; push_res = mk_vertex('0);
        v_we = 1'b0; v_wa = '0; v_wd = '0; v_re = 1'b0; v_ra = '0;
        d_we = 1'b0; d_wa = '0; d_wd = '0; d_re = 1'b0; d_ra = '0;
        x_we = 1'b0; x_wa = '0; x_wd = '0; x_re = 1'b0; x_ra = '0;
        k_we = 1'b0; k_wa = '0; k_wd = '0; k_re = 1'b0; k_ra = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_second = 1'b0;
                    unique case (i_action)
                        ACT_ADD: begin
                            if (int'(i_from_vertex) >= NODES || int'(i_to_vertex) >= NODES
                                    || int'(need_sum) > EDGES) begin
                                push = 1'b1;
                                push_res = mk_other(KIND_ACK, '0, 1'b1);
                                n_state = S_FIN;
                            end else begin
                                n_u = i_from_vertex;
                                n_v = i_to_vertex;
                                n_both = i_both_ways;
                                n_present[VIW'(i_from_vertex)] = 1'b1;
                                n_present[VIW'(i_to_vertex)] = 1'b1;
                                n_state = S_AD_RD;
                            end
                        end
                        ACT_BFS: begin
                            if (int'(i_from_vertex) < NODES) begin
                                n_seen = '0;
                                n_seen[VIW'(i_from_vertex)] = 1'b1;
                                n_present[VIW'(i_from_vertex)] = 1'b1;
                                k_we = 1'b1;
                                k_wa = '0;
                                k_wd = {NIL, i_from_vertex};
                                n_qh = '0;
                                n_qt = CW'(1);
                                n_state = S_BQ;
                            end
                        end
                        ACT_DFS: begin
                            n_seen = '0;
                            n_scan = '0;
                            if (int'(i_from_vertex) < NODES) begin
                                n_present[VIW'(i_from_vertex)] = 1'b1;
                                n_w = i_from_vertex;
                                n_comps = CW'(1);
                                n_state = S_DROOT;
                            end else begin
                                n_comps = '0;
                                n_state = S_DSCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Append r_v to r_u's list: fetch the list ends, fill the new slot.
            S_AD_RD: begin
                v_re = 1'b1;
                v_ra = VIW'(r_u);
                d_we = 1'b1;
                d_wa = EAW'(r_used);
                d_wd = r_v;
                x_we = 1'b1;
                x_wa = EAW'(r_used);
                x_wd = NIL;
                n_state = S_AD_WR;
            end

            S_AD_WR: begin
                v_we = 1'b1;
                v_wa = VIW'(r_u);
                if (r_lv[VIW'(r_u)]) begin
                    x_we = 1'b1;
                    x_wa = EAW'(v_tail);
                    x_wd = r_used;
                    v_wd = {v_head, r_used};
                end else begin
                    v_wd = {r_used, r_used};
                    n_lv[VIW'(r_u)] = 1'b1;
                end
                n_used = r_used + EW'(1);
                if (r_both && !r_second) begin
                    n_u = r_v;
                    n_v = r_u;
                    n_second = 1'b1;
                    n_state = S_AD_RD;
                end else begin
                    push = 1'b1;
                    push_res = mk_other(KIND_ACK, '0, 1'b0);
                    n_state = S_FIN;
                end
            end

            S_FIN: begin
                fin = 1'b1;
                if (push_ok) begin
                    n_state = S_IDLE;
                end
            end

            S_BQ: begin
                if (r_qh == r_qt) begin
                    n_state = S_FIN;
                end else begin
                    k_re = 1'b1;
                    k_ra = VIW'(r_qh);
                    n_qh = r_qh + CW'(1);
                    n_state = S_BU;
                end
            end

            S_BU: begin
                push = 1'b1;
                push_res = mk_vertex(k_vtx);
                if (push_ok) begin
                    if (r_lv[VIW'(k_vtx)]) begin
                        v_re = 1'b1;
                        v_ra = VIW'(k_vtx);
                        n_state = S_BH;
                    end else begin
                        n_state = S_BQ;
                    end
                end
            end

            S_BH: begin
                d_re = 1'b1;
                d_ra = EAW'(v_head);
                x_re = 1'b1;
                x_ra = EAW'(v_head);
                n_state = S_BED;
            end

            // One edge of the current list per cycle.
            S_BED: begin
                if (w_ok && int'(r_qt) < NODES) begin
                    n_seen[VIW'(d_rd)] = 1'b1;
                    k_we = 1'b1;
                    k_wa = VIW'(r_qt);
                    k_wd = {NIL, d_rd};
                    n_qt = r_qt + CW'(1);
                end
                if (x_rd == NIL) begin
                    n_state = S_BQ;
                end else begin
                    d_re = 1'b1;
                    d_ra = EAW'(x_rd);
                    x_re = 1'b1;
                    x_ra = EAW'(x_rd);
                end
            end

            // Start a depth-first tree at r_w.
            S_DROOT: begin
                push = 1'b1;
                push_res = mk_vertex(r_w);
                if (push_ok) begin
                    n_seen[VIW'(r_w)] = 1'b1;
                    v_re = 1'b1;
                    v_ra = VIW'(r_w);
                    n_state = S_DRH;
                end
            end

            S_DRH: begin
                k_we = 1'b1;
                k_wa = '0;
                k_wd = {(r_lv[VIW'(r_w)] ? v_head : NIL), r_w};
                n_sp = CW'(1);
                n_state = S_DTOP;
            end

            S_DTOP: begin
                if (r_sp == '0) begin
                    n_state = S_DSCAN;
                end else begin
                    k_re = 1'b1;
                    k_ra = VIW'(r_sp - CW'(1));
                    n_state = S_DTP;
                end
            end

            S_DTP: begin
                if (k_ptr == NIL) begin
                    n_sp = r_sp - CW'(1);
                    n_state = S_DTOP;
                end else begin
                    d_re = 1'b1;
                    d_ra = EAW'(k_ptr);
                    x_re = 1'b1;
                    x_ra = EAW'(k_ptr);
                    n_state = S_DED;
                end
            end

            // Skip seen neighbors; on an unseen one, descend into it.
            S_DED: begin
                if (w_ok) begin
                    push = 1'b1;
                    push_res = mk_vertex(d_rd);
                    if (push_ok) begin
                        k_we = 1'b1;
                        k_wa = VIW'(r_sp - CW'(1));
                        k_wd = {x_rd, d_rd};
                        n_seen[VIW'(d_rd)] = 1'b1;
                        if (int'(r_sp) < NODES) begin
                            n_w = d_rd;
                            v_re = 1'b1;
                            v_ra = VIW'(d_rd);
                            n_state = S_DWH;
                        end else begin
                            n_state = S_DTOP;
                        end
                    end
                end else if (x_rd == NIL) begin
                    n_sp = r_sp - CW'(1);
                    n_state = S_DTOP;
                end else begin
                    d_re = 1'b1;
                    d_ra = EAW'(x_rd);
                    x_re = 1'b1;
                    x_ra = EAW'(x_rd);
                end
            end

            S_DWH: begin
                k_we = 1'b1;
                k_wa = VIW'(r_sp);
                k_wd = {(r_lv[VIW'(r_w)] ? v_head : NIL), r_w};
                n_sp = r_sp + CW'(1);
                n_state = S_DTOP;
            end

            // Restart from each present, unseen vertex in ascending order.
            S_DSCAN: begin
                if (int'(r_scan) >= NODES) begin
                    push = 1'b1;
                    push_res = mk_other(KIND_COUNT, COMP_W'(r_comps), 1'b0);
                    if (push_ok) begin
                        n_state = S_FIN;
                    end
                end else if (r_present[VIW'(r_scan)] && !r_seen[VIW'(r_scan)]) begin
                    n_w = VERT_W'(r_scan);
                    n_comps = r_comps + CW'(1);
                    n_state = S_DROOT;
                end else begin
                    n_scan = r_scan + CW'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register and the one-deep hold register.
    always_comb begin
        n_pv    = r_pv;
        n_pend  = r_pend;
        n_out   = r_out;
        n_olast = r_olast;
        n_ov    = r_ov && i_out_stall;
        if (push && push_ok) begin
            if (r_pv) begin
                n_out   = r_pend;
                n_olast = 1'b0;
                n_ov    = 1'b1;
            end
            n_pend = push_res;
            n_pv   = 1'b1;
        end else if (fin && push_ok) begin
            if (r_pv) begin
                n_out   = r_pend;
                n_olast = 1'b1;
                n_ov    = 1'b1;
            end
            n_pv = 1'b0;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_ov;
    assign o_kind       = r_out.kind;
    assign o_vertex     = r_out.vertex;
    assign o_components = r_out.comps;
    assign o_store_full = r_out.full;
    assign o_last       = r_olast;

endmodule

// ----- hdl/gbt_checker.sv -----
module gbt_checker
    import gbt_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [1:0]        o_kind,
    input logic [COMP_W-1:0] o_components,
    input logic              o_store_full,
    input logic              o_last
);

    // A stalled word stays on the port.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind) && $stable(o_last))
        else $error("stalled output word changed");

    // An acknowledgement is the only word of an edge add.
    a_ack_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_ACK |-> o_last && o_components == '0)
        else $error("ack not marked last");

    // The component count closes a depth-first run.
    a_cnt_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_COUNT |-> o_last && !o_store_full)
        else $error("count not marked last");

    // A visited vertex carries no count and no full flag.
    a_vtx_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_VERTEX |-> o_components == '0 && !o_store_full)
        else $error("vertex word has stray fields");

endmodule

bind graph_bfs_dfs_traversal_core gbt_checker u_gbt_checker (.*);
